// ===== rtl/chss_pkg.sv =====
// Package with shared widths, constants and types for the cubic Hermite spline sampler.
package chss_pkg;
   localparam int COORD_BITS = 20;
   localparam int TAN_BITS = COORD_BITS + 2;
   localparam int MAX_RES = 30;
   localparam int RES_BITS = 5;
   localparam int CNT_BITS = 6;
   localparam int MUL_BITS = 24;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int DIV_BITS = 42;
   localparam int DEN_BITS = 17;
   localparam int DCNT_BITS = 6;
   localparam int IDX_BITS = 2;

   localparam logic [IDX_BITS-1:0] REG_RESOLUTION = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_TANGENT_MODE = 2'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;
endpackage

// ===== rtl/cubic_hermite_spline_sampler.sv =====
// Top level of the cubic Hermite spline sampler: point store, sequencer and output register.
// Each request is captured and dispatched; each emitted interval yields n+1 samples,
// computed one at a time by the single shared multiplier and the bit-serial divider.
// Requests are taken only while the sequencer is idle; each sample waits in the
// output register until taken. Synchronous active-high reset restores resolution 8,
// automatic tangents and an empty curve.
module cubic_hermite_spline_sampler
   import chss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x, point_y, point_z, knot_x, knot_y, knot_z
   input  logic [6*COORD_BITS-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // curve_x, curve_y, curve_z, zero fill
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [IDX_BITS-1:0]   csr_index,
   input  logic [RES_BITS-1:0]   csr_wdata
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DISP = 4'd1;
   localparam logic [3:0] ST_N0 = 4'd2;
   localparam logic [3:0] ST_N1 = 4'd3;
   localparam logic [3:0] ST_C0 = 4'd4;
   localparam logic [3:0] ST_C1 = 4'd5;
   localparam logic [3:0] ST_C2 = 4'd6;
   localparam logic [3:0] ST_C3 = 4'd7;
   localparam logic [3:0] ST_C4 = 4'd8;
   localparam logic [3:0] ST_C5 = 4'd9;
   localparam logic [3:0] ST_C6 = 4'd10;
   localparam logic [3:0] ST_MAC = 4'd11;
   localparam logic [3:0] ST_DIV = 4'd12;
   localparam logic [3:0] ST_OUT = 4'd13;

   localparam logic [DIV_BITS-1:0] SAT_HI = DIV_BITS'((1 << (COORD_BITS - 1)) - 1);
   localparam logic [DIV_BITS-1:0] SAT_LO = DIV_BITS'(1 << (COORD_BITS - 1));

   logic [3:0]            state_ff;
   logic [RES_BITS-1:0]   res_ff;
   logic                  mode_ff;
   logic [1:0]            seen_ff;
   logic signed [COORD_BITS-1:0] old_p_ff [3];
   logic signed [COORD_BITS-1:0] new_p_ff [3];
   logic signed [TAN_BITS-1:0]   old_t_ff [3];
   logic signed [TAN_BITS-1:0]   new_t_ff [3];
   logic signed [COORD_BITS-1:0] in_p_ff [3];
   logic signed [TAN_BITS-1:0]   in_d_ff [3];
   logic                  in_last_ff;
   logic signed [COORD_BITS-1:0] w_p0_ff [3];
   logic signed [COORD_BITS-1:0] w_p1_ff [3];
   logic signed [TAN_BITS-1:0]   w_d0_ff [3];
   logic signed [TAN_BITS-1:0]   w_d1_ff [3];
   logic                  pend_ff;
   logic [CNT_BITS-1:0]   n_ff;
   logic [CNT_BITS-1:0]   s_ff;
   logic [DEN_BITS-1:0]   n3_ff;
   logic signed [MUL_BITS-1:0] t1_ff;
   logic signed [MUL_BITS-1:0] ss_ff;
   logic signed [MUL_BITS-1:0] c00_ff;
   logic signed [MUL_BITS-1:0] c01_ff;
   logic signed [MUL_BITS-1:0] c10_ff;
   logic signed [MUL_BITS-1:0] c11_ff;
   logic [2:0]            k_ff;
   logic [1:0]            j_ff;
   logic signed [PROD_BITS-1:0] acc_ff;
   logic                  neg_ff;
   logic [COORD_BITS-1:0] res_x_ff [3];
   logic                  rsp_valid_ff;
   logic                  rsp_last_ff;

   logic signed [MUL_BITS-1:0]  mul_a;
   logic signed [MUL_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0] prod;
   logic                  div_start;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [DIV_BITS-1:0]   quotient;
   div_status_type        div_status;
   logic [CNT_BITS-1:0]   u_val;
   logic [CNT_BITS-1:0]   n_start;
   logic signed [PROD_BITS-1:0] acc_abs;
   logic [COORD_BITS-1:0] sat_val;

   assign u_val = n_ff - s_ff;
   assign n_start = (res_ff > RES_BITS'(MAX_RES)) ? CNT_BITS'(MAX_RES + 1)
                                                  : CNT_BITS'(res_ff) + 1'b1;
   assign acc_abs = acc_ff[PROD_BITS-1] ? -acc_ff : acc_ff;
   assign div_dividend = acc_abs[DIV_BITS-1:0] + DIV_BITS'(n3_ff);
   assign div_start = (state_ff == ST_MAC) && (k_ff == 3'd5);

   always_comb begin
      if (!neg_ff) begin
         sat_val = (quotient > SAT_HI) ? SAT_HI[COORD_BITS-1:0] : quotient[COORD_BITS-1:0];
      end else begin
         sat_val = (quotient > SAT_LO) ? SAT_LO[COORD_BITS-1:0]
                                       : COORD_BITS'(-quotient[COORD_BITS-1:0]);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_N0: begin
            mul_a = MUL_BITS'(n_ff);
            mul_b = MUL_BITS'(n_ff);
         end
         ST_N1: begin
            mul_a = prod[MUL_BITS-1:0];
            mul_b = MUL_BITS'(n_ff);
         end
         ST_C0: begin
            mul_a = MUL_BITS'(u_val);
            mul_b = MUL_BITS'(u_val);
         end
         ST_C1: begin
            mul_a = MUL_BITS'(s_ff);
            mul_b = prod[MUL_BITS-1:0];
         end
         ST_C2: begin
            mul_a = MUL_BITS'(n_ff) + MUL_BITS'({s_ff, 1'b0});
            mul_b = {t1_ff[MUL_BITS-2:0], 1'b0};
         end
         ST_C3: begin
            mul_a = MUL_BITS'(s_ff);
            mul_b = MUL_BITS'(s_ff);
         end
         ST_C4: begin
            mul_a = MUL_BITS'({n_ff, 1'b0}) + MUL_BITS'(n_ff) - MUL_BITS'({s_ff, 1'b0});
            mul_b = {prod[MUL_BITS-2:0], 1'b0};
         end
         ST_C5: begin
            mul_a = ss_ff;
            mul_b = MUL_BITS'(u_val);
         end
         ST_MAC: begin
            case (k_ff)
               3'd0: begin
                  mul_a = c00_ff;
                  mul_b = MUL_BITS'(w_p0_ff[j_ff]);
               end
               3'd1: begin
                  mul_a = c01_ff;
                  mul_b = MUL_BITS'(w_p1_ff[j_ff]);
               end
               3'd2: begin
                  mul_a = c10_ff;
                  mul_b = MUL_BITS'(w_d0_ff[j_ff]);
               end
               3'd3: begin
                  mul_a = c11_ff;
                  mul_b = MUL_BITS'(w_d1_ff[j_ff]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   chss_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   chss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({n3_ff[DEN_BITS-2:0], 1'b0}),
      .quotient (quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_ff <= RES_BITS'(8);
         mode_ff <= 1'b0;
         seen_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            old_p_ff[i] <= '0;
            new_p_ff[i] <= '0;
            old_t_ff[i] <= '0;
            new_t_ff[i] <= '0;
         end
      end else begin
         if (csr_we && csr_index == REG_RESOLUTION) begin
            res_ff <= csr_wdata;
         end else if (csr_we && csr_index == REG_TANGENT_MODE) begin
            mode_ff <= csr_wdata[0];
            seen_ff <= 2'd0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < 3; i++) begin
                     in_p_ff[i] <= req_tdata[i*COORD_BITS +: COORD_BITS];
                     in_d_ff[i] <= TAN_BITS'(2 * (TAN_BITS'(signed'(
                                   req_tdata[(i+3)*COORD_BITS +: COORD_BITS]))
                                   - TAN_BITS'(signed'(req_tdata[i*COORD_BITS +: COORD_BITS]))));
                  end
                  in_last_ff <= req_tlast;
                  state_ff <= ST_DISP;
               end
            end
            ST_DISP: begin
               pend_ff <= 1'b0;
               state_ff <= ST_IDLE;
               if (mode_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     new_p_ff[i] <= in_p_ff[i];
                     new_t_ff[i] <= in_d_ff[i];
                     old_p_ff[i] <= new_p_ff[i];
                     old_t_ff[i] <= new_t_ff[i];
                     w_p0_ff[i] <= new_p_ff[i];
                     w_d0_ff[i] <= new_t_ff[i];
                     w_p1_ff[i] <= in_p_ff[i];
                     w_d1_ff[i] <= in_d_ff[i];
                  end
                  if (seen_ff != 2'd0) begin
                     n_ff <= n_start;
                     state_ff <= ST_N0;
                  end
                  seen_ff <= in_last_ff ? 2'd0 : ((seen_ff == 2'd0) ? 2'd1 : 2'd2);
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     new_p_ff[i] <= in_p_ff[i];
                  end
                  if (seen_ff == 2'd1) begin
                     for (int i = 0; i < 3; i++) begin
                        old_p_ff[i] <= new_p_ff[i];
                        old_t_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(new_p_ff[i]);
                     end
                     if (in_last_ff) begin
                        state_ff <= ST_N0;
                     end
                  end else if (seen_ff == 2'd2) begin
                     for (int i = 0; i < 3; i++) begin
                        old_p_ff[i] <= new_p_ff[i];
                        old_t_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(old_p_ff[i]);
                        w_p0_ff[i] <= old_p_ff[i];
                        w_p1_ff[i] <= new_p_ff[i];
                        w_d0_ff[i] <= old_t_ff[i];
                        w_d1_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(old_p_ff[i]);
                     end
                     pend_ff <= in_last_ff;
                     n_ff <= n_start;
                     state_ff <= ST_N0;
                  end
                  seen_ff <= in_last_ff ? 2'd0 : ((seen_ff == 2'd0) ? 2'd1 : 2'd2);
               end
               s_ff <= '0;
               if (!mode_ff && seen_ff == 2'd1 && in_last_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     w_p0_ff[i] <= new_p_ff[i];
                     w_p1_ff[i] <= in_p_ff[i];
                     w_d0_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(new_p_ff[i]);
                     w_d1_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(new_p_ff[i]);
                     new_t_ff[i] <= TAN_BITS'(in_p_ff[i]) - TAN_BITS'(new_p_ff[i]);
                  end
                  n_ff <= n_start;
               end
            end
            ST_N0: state_ff <= ST_N1;
            ST_N1: state_ff <= ST_C0;
            ST_C0: begin
               if (s_ff == '0) begin
                  n3_ff <= prod[DEN_BITS-1:0];
               end
               state_ff <= ST_C1;
            end
            ST_C1: begin
               t1_ff <= prod[MUL_BITS-1:0];
               state_ff <= ST_C2;
            end
            ST_C2: begin
               c10_ff <= prod[MUL_BITS-1:0];
               state_ff <= ST_C3;
            end
            ST_C3: begin
               c00_ff <= prod[MUL_BITS-1:0];
               state_ff <= ST_C4;
            end
            ST_C4: begin
               ss_ff <= prod[MUL_BITS-1:0];
               state_ff <= ST_C5;
            end
            ST_C5: begin
               c01_ff <= prod[MUL_BITS-1:0];
               state_ff <= ST_C6;
            end
            ST_C6: begin
               c11_ff <= -prod[MUL_BITS-1:0];
               j_ff <= 2'd0;
               k_ff <= 3'd0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (k_ff == 3'd0) begin
                  acc_ff <= '0;
               end else begin
                  acc_ff <= acc_ff + prod;
               end
               if (k_ff == 3'd5) begin
                  neg_ff <= acc_ff[PROD_BITS-1];
                  state_ff <= ST_DIV;
               end
               k_ff <= k_ff + 1'b1;
            end
            ST_DIV: begin
               if (div_status.done) begin
                  res_x_ff[j_ff] <= sat_val;
                  k_ff <= 3'd0;
                  if (j_ff == 2'd2) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff <= (s_ff == n_ff) && !pend_ff;
                     state_ff <= ST_OUT;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (s_ff != n_ff) begin
                     s_ff <= s_ff + 1'b1;
                     state_ff <= ST_C0;
                  end else if (pend_ff) begin
                     pend_ff <= 1'b0;
                     s_ff <= '0;
                     n_ff <= n_start;
                     for (int i = 0; i < 3; i++) begin
                        w_p0_ff[i] <= old_p_ff[i];
                        w_p1_ff[i] <= new_p_ff[i];
                        w_d0_ff[i] <= old_t_ff[i];
                        w_d1_ff[i] <= TAN_BITS'(new_p_ff[i]) - TAN_BITS'(old_p_ff[i]);
                        new_t_ff[i] <= TAN_BITS'(new_p_ff[i]) - TAN_BITS'(old_p_ff[i]);
                     end
                     state_ff <= ST_N0;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {4'd0, res_x_ff[2], res_x_ff[1], res_x_ff[0]};

   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while a sample waits");
   a_seen_code: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3) else $error("point count out of range");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV) else $error("divider finished out of turn");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy) else $error("divider started while busy");
endmodule

// ===== rtl/chss_mul.sv =====
// Shared signed multiplier with a registered product.
module chss_mul
   import chss_pkg::*;
(
   input  logic                        clock,
   input  logic signed [MUL_BITS-1:0]  op_a,
   input  logic signed [MUL_BITS-1:0]  op_b,
   output logic signed [PROD_BITS-1:0] prod
);
   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule

// ===== rtl/chss_div.sv =====
// Restoring divider that yields one quotient bit per cycle while busy.
module chss_div
   import chss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic [DIV_BITS-1:0] quotient,
   output div_status_type      status
);
   logic [DIV_BITS-1:0]  quo_ff;
   logic [DEN_BITS-1:0]  rem_ff;
   logic [DEN_BITS-1:0]  den_ff;
   logic [DCNT_BITS-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DEN_BITS:0]    rem_sh;
   logic                 fits;
   logic [DEN_BITS:0]    rem_sub;

   assign rem_sh = {rem_ff, quo_ff[DIV_BITS-1]};
   assign fits = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= DCNT_BITS'(DIV_BITS - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_BITS-2:0], fits};
         rem_ff <= fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      end
   end

   assign quotient = quo_ff;
   assign status = '{busy: busy_ff, done: done_ff};
endmodule
